/* rtl/wavc_pkg.sv */
package wavc_pkg;

    localparam int HDR_LEN = 44;
    localparam int POS_W   = 6;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);

    localparam logic [3:0] ST_HDR_PEND   = 4'd0;
    localparam logic [3:0] ST_HDR_OK     = 4'd1;
    localparam logic [3:0] ST_DATA_PEND  = 4'd2;
    localparam logic [3:0] ST_STREAM_OK  = 4'd3;
    localparam logic [3:0] ST_SHORT      = 4'd4;
    localparam logic [3:0] ST_ERR_RIFF   = 4'd5;
    localparam logic [3:0] ST_ERR_WAVE   = 4'd6;
    localparam logic [3:0] ST_ERR_FMT    = 4'd7;
    localparam logic [3:0] ST_ERR_FSIZE  = 4'd8;
    localparam logic [3:0] ST_ERR_FCODE  = 4'd9;
    localparam logic [3:0] ST_ERR_CHAN   = 4'd10;
    localparam logic [3:0] ST_ERR_BRATE  = 4'd11;
    localparam logic [3:0] ST_ERR_BITS   = 4'd12;
    localparam logic [3:0] ST_ERR_ALIGN  = 4'd13;
    localparam logic [3:0] ST_ERR_DTAG   = 4'd14;
    localparam logic [3:0] ST_TRAILING   = 4'd15;

    localparam int TAG_RIFF = 0;
    localparam int TAG_WAVE = 1;
    localparam int TAG_FMT  = 2;
    localparam int TAG_DATA = 3;

    localparam logic [15:0][7:0] TAG_TEXT = {
        8'h61, 8'h74, 8'h61, 8'h64,   // "data" (msb first)
        8'h20, 8'h74, 8'h6d, 8'h66,   // "fmt "
        8'h45, 8'h56, 8'h41, 8'h57,   // "WAVE"
        8'h46, 8'h46, 8'h49, 8'h52    // "RIFF"
    };

    typedef struct packed {
        logic [31:0] riff_size;
        logic [31:0] fmt_size;
        logic [15:0] fmt_code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [31:0] byte_rate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] chunk_len;
        logic [3:0]  tag_ok;
    } hdr_t;

endpackage

/* rtl/wavc_ifs.sv */
interface wavc_in_if import wavc_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, data_byte, end_of_input, input ready);
    modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface wavc_out_if import wavc_pkg::*;;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] file_size;
    logic [15:0] channel_count;
    logic [31:0] sample_hz;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
    logic [31:0] chunk_len;

    modport source (output valid, status, file_size, channel_count, sample_hz,
                    bytes_per_second, frame_align, sample_bits, chunk_len,
                    input ready);
    modport sink   (input valid, status, file_size, channel_count, sample_hz,
                    bytes_per_second, frame_align, sample_bits, chunk_len,
                    output ready);
endinterface

/* rtl/wavc_hdr_capture.sv */
module wavc_hdr_capture import wavc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             restart,
    input  logic [7:0]       data_byte,
    output logic [POS_W-1:0] pos,
    output hdr_t             hdr,
    output hdr_t             hdr_wr
);

    localparam hdr_t HDR_RST = '{tag_ok: 4'hF, default: '0};

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    hdr_t             hdr_reg;
    hdr_t             hdr_next;
    logic [4:0]       sh32;
    logic [3:0]       sh16;
    logic             is_tag;
    logic [1:0]       tag_sel;

    assign sh32 = {pos_reg[1:0], 3'b000};
    assign sh16 = {pos_reg[0], 3'b000};

    always_comb
    begin
        hdr_wr  = hdr_reg;
        is_tag  = 1'b0;
        tag_sel = 2'(TAG_RIFF);
        if (take)
        begin
            if (pos_reg < 6'd4)
            begin
                is_tag  = 1'b1;
                tag_sel = 2'(TAG_RIFF);
            end
            else if (pos_reg < 6'd8)
                hdr_wr.riff_size[sh32 +: 8] = data_byte;
            else if (pos_reg < 6'd12)
            begin
                is_tag  = 1'b1;
                tag_sel = 2'(TAG_WAVE);
            end
            else if (pos_reg < 6'd16)
            begin
                is_tag  = 1'b1;
                tag_sel = 2'(TAG_FMT);
            end
            else if (pos_reg < 6'd20)
                hdr_wr.fmt_size[sh32 +: 8] = data_byte;
            else if (pos_reg < 6'd22)
                hdr_wr.fmt_code[sh16 +: 8] = data_byte;
            else if (pos_reg < 6'd24)
                hdr_wr.channels[sh16 +: 8] = data_byte;
            else if (pos_reg < 6'd28)
                hdr_wr.rate[sh32 +: 8] = data_byte;
            else if (pos_reg < 6'd32)
                hdr_wr.byte_rate[sh32 +: 8] = data_byte;
            else if (pos_reg < 6'd34)
                hdr_wr.align[sh16 +: 8] = data_byte;
            else if (pos_reg < 6'd36)
                hdr_wr.bits[sh16 +: 8] = data_byte;
            else if (pos_reg < 6'd40)
            begin
                is_tag  = 1'b1;
                tag_sel = 2'(TAG_DATA);
            end
            else
                hdr_wr.chunk_len[sh32 +: 8] = data_byte;

            if (is_tag && (data_byte != TAG_TEXT[{tag_sel, pos_reg[1:0]}]))
                hdr_wr.tag_ok[tag_sel] = 1'b0;
        end
    end

    always_comb
    begin
        hdr_next = hdr_wr;
        pos_next = pos_reg;
        if (restart)
        begin
            hdr_next = HDR_RST;
            pos_next = '0;
        end
        else if (take && (pos_reg != POS_LAST))
            pos_next = pos_reg + 1'b1;
        else if (take)
            pos_next = POS_W'(HDR_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= HDR_RST;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
        end
    end

    assign pos = pos_reg;
    assign hdr = hdr_reg;

endmodule

/* rtl/wavc_judge.sv */
module wavc_judge import wavc_pkg::*;
(
    input  logic       clk,
    input  hdr_t       hdr,
    output logic [3:0] verdict
);

    // products settle long before the last header byte
    logic [47:0] rate_prod;
    logic [28:0] align_prod;
    logic [31:0] brate_exp_reg;
    logic [28:0] align_exp_reg;

    assign rate_prod  = hdr.rate * hdr.align;
    assign align_prod = hdr.bits[15:3] * hdr.channels;

    always_ff @(posedge clk)
    begin
        brate_exp_reg <= rate_prod[31:0];
        align_exp_reg <= align_prod;
    end

    always_comb
    begin
        if (!hdr.tag_ok[TAG_RIFF])
            verdict = ST_ERR_RIFF;
        else if (!hdr.tag_ok[TAG_WAVE])
            verdict = ST_ERR_WAVE;
        else if (!hdr.tag_ok[TAG_FMT])
            verdict = ST_ERR_FMT;
        else if (hdr.fmt_size != 32'd16)
            verdict = ST_ERR_FSIZE;
        else if (hdr.fmt_code != 16'd1)
            verdict = ST_ERR_FCODE;
        else if (!(hdr.channels == 16'd1 || hdr.channels == 16'd2))
            verdict = ST_ERR_CHAN;
        else if (hdr.byte_rate != brate_exp_reg)
            verdict = ST_ERR_BRATE;
        else if (!(hdr.bits == 16'd8 || hdr.bits == 16'd16))
            verdict = ST_ERR_BITS;
        else if ({13'd0, hdr.align} != align_exp_reg)
            verdict = ST_ERR_ALIGN;
        else if (!hdr.tag_ok[TAG_DATA])
            verdict = ST_ERR_DTAG;
        else
            verdict = ST_HDR_OK;
    end

endmodule

/* rtl/wav_header_stream_checker_core.sv */
// channel  dir  contents
// stream   in   data_byte[7:0], end_of_input
// result   out  status[3:0], file_size, channel_count, sample_hz,
//               bytes_per_second, frame_align, sample_bits, chunk_len
//
// One transfer in, one registered result out in the cycle after it; a new byte
// is taken every cycle that stream.ready is high. Result register in front of
// the output: stream.ready drops only while a result is held and result.ready
// is low. Header checks use products registered from the captured fields. Reset
// and every end marker return the parser to header pending at byte 0.
module wav_header_stream_checker_core import wavc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wavc_in_if.sink     stream,
    wavc_out_if.source  result
);

    logic             in_xfer;
    logic             take;
    logic             restart;
    logic [POS_W-1:0] pos;
    hdr_t             hdr;
    hdr_t             hdr_wr;
    logic [3:0]       judge_code;

    logic [3:0]  verdict_reg;
    logic [3:0]  verdict_next;
    logic [31:0] seen_reg;
    logic [31:0] seen_next;
    logic [3:0]  status_next;

    logic        out_valid_reg;
    logic [3:0]  status_reg;
    hdr_t        fields_reg;

    assign stream.ready = !out_valid_reg || result.ready;
    assign in_xfer      = stream.valid && stream.ready;
    assign restart      = in_xfer && stream.end_of_input;
    assign take         = in_xfer && !stream.end_of_input && (verdict_reg == ST_HDR_PEND);

    wavc_hdr_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .restart   (restart),
        .data_byte (stream.data_byte),
        .pos       (pos),
        .hdr       (hdr),
        .hdr_wr    (hdr_wr)
    );

    wavc_judge u_judge (
        .clk     (clk),
        .hdr     (hdr),
        .verdict (judge_code)
    );

    always_comb
    begin
        verdict_next = verdict_reg;
        seen_next    = seen_reg;
        status_next  = verdict_reg;
        if (stream.end_of_input)
        begin
            if (verdict_reg == ST_HDR_OK)
                status_next = (seen_reg < hdr.chunk_len) ? ST_SHORT : ST_STREAM_OK;
            else if (verdict_reg == ST_HDR_PEND)
                status_next = ST_SHORT;
            verdict_next = ST_HDR_PEND;
            seen_next    = '0;
        end
        else if (verdict_reg == ST_HDR_PEND)
        begin
            status_next = ST_HDR_PEND;
            if (pos == POS_LAST)
            begin
                verdict_next = judge_code;
                status_next  = judge_code;
            end
        end
        else if (verdict_reg == ST_HDR_OK)
        begin
            if (seen_reg < hdr.chunk_len)
            begin
                seen_next   = seen_reg + 32'd1;
                status_next = ST_DATA_PEND;
            end
            else
            begin
                verdict_next = ST_TRAILING;
                status_next  = ST_TRAILING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_reg   <= ST_HDR_PEND;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                verdict_reg <= verdict_next;
                seen_reg    <= seen_next;
            end
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg <= status_next;
            fields_reg <= hdr_wr;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = status_reg;
    assign result.file_size        = fields_reg.riff_size;
    assign result.channel_count    = fields_reg.channels;
    assign result.sample_hz        = fields_reg.rate;
    assign result.bytes_per_second = fields_reg.byte_rate;
    assign result.frame_align      = fields_reg.align;
    assign result.sample_bits      = fields_reg.bits;
    assign result.chunk_len        = fields_reg.chunk_len;

    a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !(verdict_reg == ST_DATA_PEND || verdict_reg == ST_STREAM_OK
          || verdict_reg == ST_SHORT))
        else $error("verdict holds a transient status");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (verdict_reg == ST_HDR_PEND && pos == '0 && seen_reg == '0))
        else $error("end marker did not restart the parser");

    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !stream.end_of_input && verdict_reg == ST_HDR_OK)
        |=> (status_reg == ST_DATA_PEND || status_reg == ST_TRAILING))
        else $error("data byte gave a wrong status");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_reg == ST_HDR_OK) |-> (seen_reg <= hdr.chunk_len))
        else $error("data count passed the chunk size");

endmodule

/* bench/wav_header_stream_checker_core_tb.sv */
module wav_header_stream_checker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavc_pkg::*;

    typedef struct {
        logic [3:0]  status;
        logic [31:0] file_size;
        logic [15:0] channel_count;
        logic [31:0] sample_hz;
        logic [31:0] bytes_per_second;
        logic [15:0] frame_align;
        logic [15:0] sample_bits;
        logic [31:0] chunk_len;
    } wav_result_t;

    typedef enum int {
        FLAW_NONE, FLAW_RIFF, FLAW_WAVE, FLAW_FMT, FLAW_FSIZE, FLAW_FCODE,
        FLAW_CHAN, FLAW_BRATE, FLAW_BITS, FLAW_ALIGN, FLAW_DTAG, FLAW_NOISE
    } flaw_e;

    class wav_scoreboard;
        wav_result_t verdict_q[$];
        int          errors;

        int          hdr_pos;
        logic [31:0] riff_sz;
        logic [31:0] fmt_sz;
        logic [15:0] fmt_cd;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] dsize;
        logic [3:0]  tag_ok;
        logic [3:0]  verdict;
        logic [31:0] data_seen;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            hdr_pos   = 0;
            riff_sz   = '0;
            fmt_sz    = '0;
            fmt_cd    = '0;
            chans     = '0;
            rate      = '0;
            brate     = '0;
            align     = '0;
            bits      = '0;
            dsize     = '0;
            tag_ok    = 4'hF;
            verdict   = ST_HDR_PEND;
            data_seen = '0;
        endfunction

        function void take_byte(int p, logic [7:0] b);
            if (p < 4) begin
                if (b != TAG_TEXT[TAG_RIFF*4 + p]) tag_ok[TAG_RIFF] = 1'b0;
            end else if (p < 8)
                riff_sz[(p-4)*8 +: 8] = b;
            else if (p < 12) begin
                if (b != TAG_TEXT[TAG_WAVE*4 + p-8]) tag_ok[TAG_WAVE] = 1'b0;
            end else if (p < 16) begin
                if (b != TAG_TEXT[TAG_FMT*4 + p-12]) tag_ok[TAG_FMT] = 1'b0;
            end else if (p < 20)
                fmt_sz[(p-16)*8 +: 8] = b;
            else if (p < 22)
                fmt_cd[(p-20)*8 +: 8] = b;
            else if (p < 24)
                chans[(p-22)*8 +: 8] = b;
            else if (p < 28)
                rate[(p-24)*8 +: 8] = b;
            else if (p < 32)
                brate[(p-28)*8 +: 8] = b;
            else if (p < 34)
                align[(p-32)*8 +: 8] = b;
            else if (p < 36)
                bits[(p-34)*8 +: 8] = b;
            else if (p < 40) begin
                if (b != TAG_TEXT[TAG_DATA*4 + p-36]) tag_ok[TAG_DATA] = 1'b0;
            end else
                dsize[(p-40)*8 +: 8] = b;
        endfunction

        function logic [3:0] judge_header();
            logic [31:0] rate_x_align;
            logic [31:0] want_align;
            rate_x_align = rate * {16'd0, align};
            want_align   = ({16'd0, bits} / 32'd8) * {16'd0, chans};
            if (!tag_ok[TAG_RIFF]) return ST_ERR_RIFF;
            if (!tag_ok[TAG_WAVE]) return ST_ERR_WAVE;
            if (!tag_ok[TAG_FMT]) return ST_ERR_FMT;
            if (fmt_sz != 32'd16) return ST_ERR_FSIZE;
            if (fmt_cd != 16'd1) return ST_ERR_FCODE;
            if (!(chans == 16'd1 || chans == 16'd2)) return ST_ERR_CHAN;
            if (brate != rate_x_align) return ST_ERR_BRATE;
            if (!(bits == 16'd8 || bits == 16'd16)) return ST_ERR_BITS;
            if ({16'd0, align} != want_align) return ST_ERR_ALIGN;
            if (!tag_ok[TAG_DATA]) return ST_ERR_DTAG;
            return ST_HDR_OK;
        endfunction

        function void note_input(logic [7:0] b, logic eoi);
            wav_result_t r;
            logic [3:0]  st;
            if (eoi) begin
                if (verdict >= ST_ERR_RIFF)
                    st = verdict;
                else if (verdict == ST_HDR_OK)
                    st = (data_seen < dsize) ? ST_SHORT : ST_STREAM_OK;
                else
                    st = ST_SHORT;
            end else if (verdict >= ST_ERR_RIFF) begin
                st = verdict;
            end else if (verdict == ST_HDR_PEND) begin
                take_byte(hdr_pos, b);
                hdr_pos++;
                if (hdr_pos >= HDR_LEN) begin
                    verdict = judge_header();
                    st = verdict;
                end else begin
                    st = ST_HDR_PEND;
                end
            end else if (data_seen < dsize) begin
                data_seen++;
                st = ST_DATA_PEND;
            end else begin
                verdict = ST_TRAILING;
                st = ST_TRAILING;
            end
            r.status           = st;
            r.file_size        = riff_sz;
            r.channel_count    = chans;
            r.sample_hz        = rate;
            r.bytes_per_second = brate;
            r.frame_align      = align;
            r.sample_bits      = bits;
            r.chunk_len        = dsize;
            verdict_q.push_back(r);
            if (eoi) clear_state();
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(wav_result_t got);
            wav_result_t want;
            if (verdict_q.size() == 0) begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = verdict_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.file_size !== want.file_size)
                report($sformatf("file_size %h, want %h", got.file_size, want.file_size));
            if (got.channel_count !== want.channel_count)
                report($sformatf("channel_count %h, want %h",
                                 got.channel_count, want.channel_count));
            if (got.sample_hz !== want.sample_hz)
                report($sformatf("sample_hz %h, want %h",
                                 got.sample_hz, want.sample_hz));
            if (got.bytes_per_second !== want.bytes_per_second)
                report($sformatf("bytes_per_second %h, want %h",
                                 got.bytes_per_second, want.bytes_per_second));
            if (got.frame_align !== want.frame_align)
                report($sformatf("frame_align %h, want %h",
                                 got.frame_align, want.frame_align));
            if (got.sample_bits !== want.sample_bits)
                report($sformatf("sample_bits %h, want %h",
                                 got.sample_bits, want.sample_bits));
            if (got.chunk_len !== want.chunk_len)
                report($sformatf("chunk_len %h, want %h", got.chunk_len, want.chunk_len));
        endtask
    endclass

    logic clk;
    logic rst_n;

    wavc_in_if  stream();
    wavc_out_if result();

    wav_header_stream_checker_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    wav_scoreboard sb;
    int            burst_left;
    int            sink_cyc;
    int            sink_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // sink stall pattern: switches between always ready, random, and 1-in-5
    always @(posedge clk)
    begin
        sink_cyc <= sink_cyc + 1;
        if (sink_cyc % 64 == 0)
            sink_mode <= $urandom_range(0, 2);
        case (sink_mode)
            0:       result.ready <= 1'b1;
            1:       result.ready <= 1'($urandom_range(0, 1));
            default: result.ready <= (sink_cyc % 5 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        wav_result_t got;
        if (rst_n && result.valid && result.ready) begin
            got.status           = result.status;
            got.file_size        = result.file_size;
            got.channel_count    = result.channel_count;
            got.sample_hz        = result.sample_hz;
            got.bytes_per_second = result.bytes_per_second;
            got.frame_align      = result.frame_align;
            got.sample_bits      = result.sample_bits;
            got.chunk_len        = result.chunk_len;
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eoi);
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                stream.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        stream.valid        <= 1'b1;
        stream.data_byte    <= b;
        stream.end_of_input <= eoi;
        @(posedge clk);
        while (!stream.ready) @(posedge clk);
        sb.note_input(b, eoi);
        burst_left--;
    endtask

    // cut < HDR_LEN ends the stream inside the header
    task automatic run_stream(input flaw_e flaw, input int cut, input logic [31:0] dsz,
                              input int body);
        logic [7:0]  hdr [0:43];
        logic [15:0] chans, bits, align, fcode;
        logic [31:0] riff, rate, brate, fsz;
        chans = 16'($urandom_range(1, 2));
        bits  = $urandom_range(0, 1) ? 16'd16 : 16'd8;
        align = (bits / 16'd8) * chans;
        rate  = $urandom;
        riff  = $urandom;
        fsz   = 32'd16;
        fcode = 16'd1;
        case (flaw)
            FLAW_FSIZE: begin
                fsz = $urandom;
                if (fsz == 32'd16) fsz = 32'd0;
            end
            FLAW_FCODE: begin
                fcode = 16'($urandom);
                if (fcode == 16'd1) fcode = 16'd0;
            end
            FLAW_CHAN: begin
                chans = 16'($urandom);
                if (chans == 16'd1 || chans == 16'd2) chans = 16'hFFFF;
            end
            FLAW_BITS: begin
                bits = 16'($urandom);
                if (bits == 16'd8 || bits == 16'd16) bits = 16'd0;
            end
            FLAW_ALIGN: align = align + 16'($urandom_range(1, 65535));
            default: ;
        endcase
        brate = rate * {16'd0, align};
        if (flaw == FLAW_BRATE) brate = brate ^ $urandom_range(32'hFFFF_FFFF, 1);
        for (int i = 0; i < 4; i++) begin
            hdr[i]      = TAG_TEXT[TAG_RIFF*4 + i];
            hdr[4 + i]  = riff[8*i +: 8];
            hdr[8 + i]  = TAG_TEXT[TAG_WAVE*4 + i];
            hdr[12 + i] = TAG_TEXT[TAG_FMT*4 + i];
            hdr[16 + i] = fsz[8*i +: 8];
            hdr[24 + i] = rate[8*i +: 8];
            hdr[28 + i] = brate[8*i +: 8];
            hdr[36 + i] = TAG_TEXT[TAG_DATA*4 + i];
            hdr[40 + i] = dsz[8*i +: 8];
        end
        for (int i = 0; i < 2; i++) begin
            hdr[20 + i] = fcode[8*i +: 8];
            hdr[22 + i] = chans[8*i +: 8];
            hdr[32 + i] = align[8*i +: 8];
            hdr[34 + i] = bits[8*i +: 8];
        end
        case (flaw)
            FLAW_RIFF: hdr[$urandom_range(0, 3)]   ^= 8'($urandom_range(1, 255));
            FLAW_WAVE: hdr[8 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            FLAW_FMT:  hdr[12 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            FLAW_DTAG: hdr[36 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            FLAW_NOISE:
                for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom);
            default: ;
        endcase
        for (int i = 0; i < cut && i < HDR_LEN; i++)
            send_item(hdr[i], 1'b0);
        if (cut >= HDR_LEN)
            for (int i = 0; i < body; i++)
                send_item(8'($urandom), 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        stream.valid        = 1'b0;
        stream.data_byte    = 8'd0;
        stream.end_of_input = 1'b0;
        burst_left          = 0;
        sb                  = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end marker with no bytes, twice in a row, then a cut header
        run_stream(FLAW_NONE, 0, 32'd0, 0);
        run_stream(FLAW_NONE, 0, 32'd0, 0);
        run_stream(FLAW_NONE, 17, 32'd4, 0);
        // exact data, short data, empty data chunk with trailing bytes, overrun
        run_stream(FLAW_NONE, HDR_LEN, 32'd3, 3);
        run_stream(FLAW_NONE, HDR_LEN, 32'd3, 2);
        run_stream(FLAW_NONE, HDR_LEN, 32'd0, 2);
        run_stream(FLAW_NONE, HDR_LEN, 32'd2, 4);
        for (int f = FLAW_RIFF; f <= FLAW_NOISE; f++)
            run_stream(flaw_e'(f), HDR_LEN, 32'd2, 1);
        stream.valid <= 1'b0;

        while (sb.verdict_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
